/* rtl/ils_pkg.sv */
package ils_pkg;

	// store geometry
	localparam int CAPACITY      = 256;
	localparam int ELEMENT_WIDTH = 32;
	localparam int ADDR_W        = $clog2(CAPACITY);
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int PTR_W         = $clog2(CAPACITY + 2);

	// request / result field widths
	localparam int OP_W     = 3;
	localparam int INDEX_W  = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int RDATA_W  = 32;
	localparam int COUNT_W  = 9;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND    = 3'd0,
		OP_OVERWRITE = 3'd1,
		OP_READ      = 3'd2,
		OP_DELETE    = 3'd3,
		OP_SWAP_DEL  = 3'd4,
		OP_SEARCH    = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PTR_HOLD = 3'd0,
		PTR_IDX  = 3'd1,
		PTR_IDX1 = 3'd2,
		PTR_ZERO = 3'd3,
		PTR_LAST = 3'd4,
		PTR_INC  = 3'd5
	} ptr_op_t;

	typedef enum logic [1:0] {
		WA_CNT  = 2'd0,
		WA_IDX  = 2'd1,
		WA_PREV = 2'd2
	} wsel_t;

	typedef enum logic {
		WD_VAL = 1'b0,
		WD_RD  = 1'b1
	} dsel_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2
	} cnt_op_t;

	typedef enum logic [2:0] {
		C_NONE   = 3'd0,
		C_FULL   = 3'd1,
		C_OUTR   = 3'd2,
		C_PTR_GE = 3'd3,
		C_PTR_LT = 3'd4
	} cond_t;

	// microprogram addresses
	localparam int PC_W     = 5;
	localparam int PROG_LEN = 23;

	localparam logic [PC_W-1:0] L_A0    = PC_W'(0);
	localparam logic [PC_W-1:0] L_A1    = PC_W'(1);
	localparam logic [PC_W-1:0] L_O0    = PC_W'(2);
	localparam logic [PC_W-1:0] L_O1    = PC_W'(3);
	localparam logic [PC_W-1:0] L_R0    = PC_W'(4);
	localparam logic [PC_W-1:0] L_R1    = PC_W'(5);
	localparam logic [PC_W-1:0] L_R2    = PC_W'(6);
	localparam logic [PC_W-1:0] L_D0    = PC_W'(7);
	localparam logic [PC_W-1:0] L_D1    = PC_W'(8);
	localparam logic [PC_W-1:0] L_D2    = PC_W'(9);
	localparam logic [PC_W-1:0] L_D3    = PC_W'(10);
	localparam logic [PC_W-1:0] L_DFIN  = PC_W'(11);
	localparam logic [PC_W-1:0] L_W0    = PC_W'(12);
	localparam logic [PC_W-1:0] L_W1    = PC_W'(13);
	localparam logic [PC_W-1:0] L_W2    = PC_W'(14);
	localparam logic [PC_W-1:0] L_Q0    = PC_W'(15);
	localparam logic [PC_W-1:0] L_Q1    = PC_W'(16);
	localparam logic [PC_W-1:0] L_Q2    = PC_W'(17);
	localparam logic [PC_W-1:0] L_Q3    = PC_W'(18);
	localparam logic [PC_W-1:0] L_QFIN  = PC_W'(19);
	localparam logic [PC_W-1:0] L_FULLS = PC_W'(20);
	localparam logic [PC_W-1:0] L_ERR   = PC_W'(21);
	localparam logic [PC_W-1:0] L_NOP   = PC_W'(22);

	typedef struct packed {
		ptr_op_t         ptr_op;
		logic            rd;
		logic            wr;
		wsel_t           wsel;
		dsel_t           dsel;
		cnt_op_t         cnt_op;
		logic            cmp;
		logic            rdata_en;
		logic            done;
		status_t         status;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} cw_t;

	typedef struct packed {
		logic out_range;
		logic full;
		logic ptr_ge;
	} flags_t;

	localparam cw_t CW_NOP = '{
		ptr_op:   PTR_HOLD,
		rd:       1'b0,
		wr:       1'b0,
		wsel:     WA_CNT,
		dsel:     WD_VAL,
		cnt_op:   CNT_HOLD,
		cmp:      1'b0,
		rdata_en: 1'b0,
		done:     1'b0,
		status:   ST_DONE,
		cond:     C_NONE,
		target:   L_A0
	};

	function automatic logic [PC_W-1:0] entry_pc(input logic [OP_W-1:0] op);
		logic [PC_W-1:0] pc;
		case (op)
			OP_APPEND:    pc = L_A0;
			OP_OVERWRITE: pc = L_O0;
			OP_READ:      pc = L_R0;
			OP_DELETE:    pc = L_D0;
			OP_SWAP_DEL:  pc = L_W0;
			OP_SEARCH:    pc = L_Q0;
			default:      pc = L_NOP;
		endcase
		return pc;
	endfunction

	// control store
	function automatic cw_t prog_rom(input logic [PC_W-1:0] pc);
		cw_t w;
		w = CW_NOP;
		case (pc)
			L_A0: begin
				w.cond = C_FULL; w.target = L_FULLS;
			end
			L_A1: begin
				w.wr = 1'b1; w.wsel = WA_CNT; w.dsel = WD_VAL;
				w.cnt_op = CNT_INC; w.done = 1'b1;
			end
			L_O0: begin
				w.cond = C_OUTR; w.target = L_ERR;
			end
			L_O1: begin
				w.wr = 1'b1; w.wsel = WA_IDX; w.dsel = WD_VAL; w.done = 1'b1;
			end
			L_R0: begin
				w.ptr_op = PTR_IDX; w.cond = C_OUTR; w.target = L_ERR;
			end
			L_R1: begin
				w.rd = 1'b1;
			end
			L_R2: begin
				w.rdata_en = 1'b1; w.done = 1'b1;
			end
			L_D0: begin
				w.ptr_op = PTR_IDX1; w.cond = C_OUTR; w.target = L_ERR;
			end
			L_D1: begin
				w.cond = C_PTR_GE; w.target = L_DFIN;
			end
			L_D2: begin
				w.rd = 1'b1; w.ptr_op = PTR_INC;
			end
			L_D3: begin
				w.wr = 1'b1; w.wsel = WA_PREV; w.dsel = WD_RD;
				w.rd = 1'b1; w.ptr_op = PTR_INC;
				w.cond = C_PTR_LT; w.target = L_D3;
			end
			L_DFIN: begin
				w.cnt_op = CNT_DEC; w.done = 1'b1;
			end
			L_W0: begin
				w.ptr_op = PTR_LAST; w.cond = C_OUTR; w.target = L_ERR;
			end
			L_W1: begin
				w.rd = 1'b1;
			end
			L_W2: begin
				w.wr = 1'b1; w.wsel = WA_IDX; w.dsel = WD_RD;
				w.cnt_op = CNT_DEC; w.done = 1'b1;
			end
			L_Q0: begin
				w.ptr_op = PTR_ZERO;
			end
			L_Q1: begin
				w.cond = C_PTR_GE; w.target = L_QFIN;
			end
			L_Q2: begin
				w.rd = 1'b1; w.ptr_op = PTR_INC;
			end
			L_Q3: begin
				w.cmp = 1'b1; w.rd = 1'b1; w.ptr_op = PTR_INC;
				w.cond = C_PTR_LT; w.target = L_Q3;
			end
			L_QFIN: begin
				w.done = 1'b1;
			end
			L_FULLS: begin
				w.status = ST_FULL; w.done = 1'b1;
			end
			L_ERR: begin
				w.status = ST_RANGE; w.done = 1'b1;
			end
			default: begin
				w.done = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/indexed_list_store_unit.sv */
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ------------------------------
// request   operation, index, value                 start & !busy at clk rise
// result    status, read_data, found, element_count done strobe, one cycle, no stall
//
// One request at a time: busy rises at the accepting edge, falls after the last step,
// and the done strobe rises at that same edge. Steps: append, overwrite 2; read, swap
// delete 3; unused codes 1; rejected requests 2; ordered delete 3 for the last element,
// else 4 + (count - index - 1); search 3 on an empty store, else 4 + count, one element
// per cycle through the registered read port. The receiver cannot stall; a new request
// can be accepted in the strobe cycle. Reset clears count, found, done and sequencer only.
module indexed_list_store_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ils_pkg::OP_W-1:0]     operation,
	input  logic [ils_pkg::INDEX_W-1:0]  index,
	input  logic [ils_pkg::VALUE_W-1:0]  value,
	output logic                         done,
	output logic [ils_pkg::STATUS_W-1:0] status,
	output logic [ils_pkg::RDATA_W-1:0]  read_data,
	output logic                         found,
	output logic [ils_pkg::COUNT_W-1:0]  element_count
);
	import ils_pkg::*;

	cw_t    ctrl;     // current control word, idle word when not busy
	flags_t flags;    // branch conditions back from the datapath
	logic   accept;

	assign accept = start && !busy;

	ils_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.flags     (flags),
		.ctrl      (ctrl),
		.busy      (busy)
	);

	ils_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.index         (index),
		.value         (value),
		.ctrl          (ctrl),
		.flags         (flags),
		.done          (done),
		.status        (status),
		.read_data     (read_data),
		.found         (found),
		.element_count (element_count)
	);

endmodule

/* rtl/ils_sequencer.sv */
module ils_sequencer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ils_pkg::OP_W-1:0]  operation,
	input  ils_pkg::flags_t           flags,
	output ils_pkg::cw_t              ctrl,
	output logic                      busy
);
	import ils_pkg::*;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	cw_t             word;
	logic            take;

	assign word = prog_rom(pc_q);
	assign ctrl = busy_q ? word : CW_NOP;
	assign busy = busy_q;

	always_comb begin
		case (word.cond)
			C_FULL:   take = flags.full;
			C_OUTR:   take = flags.out_range;
			C_PTR_GE: take = flags.ptr_ge;
			C_PTR_LT: take = !flags.ptr_ge;
			default:  take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= L_A0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= entry_pc(operation);
			end
		end else if (word.done) begin
			busy_q <= 1'b0;
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	// idle only after a step that delivers the result
	a_end_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(ctrl.done))
		else $error("sequencer left busy without a done step");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> busy_q)
		else $error("accepted request did not start the program");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < PC_W'(PROG_LEN)))
		else $error("step counter outside the control store");

endmodule

/* rtl/ils_datapath.sv */
module ils_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [ils_pkg::INDEX_W-1:0]  index,
	input  logic [ils_pkg::VALUE_W-1:0]  value,
	input  ils_pkg::cw_t                 ctrl,
	output ils_pkg::flags_t              flags,
	output logic                         done,
	output logic [ils_pkg::STATUS_W-1:0] status,
	output logic [ils_pkg::RDATA_W-1:0]  read_data,
	output logic                         found,
	output logic [ils_pkg::COUNT_W-1:0]  element_count
);
	import ils_pkg::*;

	logic [ELEMENT_WIDTH-1:0] store_q [CAPACITY];

	logic [INDEX_W-1:0]       idx_q;
	logic [ELEMENT_WIDTH-1:0] val_q;
	logic [ELEMENT_WIDTH-1:0] rd_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [ADDR_W-1:0]        wa_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     found_q;
	logic                     done_q;
	logic [STATUS_W-1:0]      status_q;
	logic [RDATA_W-1:0]       rdata_q;

	logic [PTR_W-1:0]         ptr_dec;
	logic [ADDR_W-1:0]        waddr;
	logic [ELEMENT_WIDTH-1:0] wdata;

	assign flags.out_range = CNT_W'(idx_q) >= cnt_q;
	assign flags.full      = cnt_q >= CNT_W'(CAPACITY);
	assign flags.ptr_ge    = ptr_q >= PTR_W'(cnt_q);

	assign ptr_dec = ptr_q - 1'b1;

	always_comb begin
		case (ctrl.wsel)
			WA_IDX:  waddr = ADDR_W'(idx_q);
			WA_PREV: waddr = wa_q;
			default: waddr = cnt_q[ADDR_W-1:0];
		endcase
		wdata = (ctrl.dsel == WD_RD) ? rd_q : val_q;
	end

	// element store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctrl.wr)
			store_q[waddr] <= wdata;
		if (ctrl.rd)
			rd_q <= store_q[ptr_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= index;
			val_q <= ELEMENT_WIDTH'(value);
		end
		if (ctrl.rd)
			wa_q <= ptr_dec[ADDR_W-1:0];
		case (ctrl.ptr_op)
			PTR_IDX:  ptr_q <= PTR_W'(idx_q);
			PTR_IDX1: ptr_q <= PTR_W'(idx_q) + 1'b1;
			PTR_ZERO: ptr_q <= '0;
			PTR_LAST: ptr_q <= PTR_W'(cnt_q) - 1'b1;
			PTR_INC:  ptr_q <= ptr_q + 1'b1;
			default:  ptr_q <= ptr_q;
		endcase
		if (ctrl.done) begin
			status_q <= ctrl.status;
			rdata_q  <= ctrl.rdata_en ? RDATA_W'(rd_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctrl.done;
			case (ctrl.cnt_op)
				CNT_INC: cnt_q <= cnt_q + 1'b1;
				CNT_DEC: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			if (accept)
				found_q <= 1'b0;
			else if (ctrl.cmp && (rd_q == val_q))
				found_q <= 1'b1;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign read_data     = rdata_q;
	assign found         = found_q;
	assign element_count = COUNT_W'(cnt_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

endmodule
